/* design/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants
// Word field types, control structs and the fixed divisor used by the
// sliding Simpson integrator.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 16;
  localparam int ANGLE_W  = 36;

  localparam int DIVISOR = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [STEP_W-1:0]   step_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;

  // window control: load shifts a new sample in, rotate cycles the taps
  typedef struct packed {
    logic load;
    logic rotate;
  } win_ctrl_t;

endpackage

/* design/ssi_ifs.sv */
// ----------------------------------------------------------------------------
// ssi_ifs: word channels
// Valid/ready channels for the sample words and the angle words.
// ----------------------------------------------------------------------------
interface ssi_in_if import ssi_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t rate_sample;
  step_t   time_step;

  modport source (output valid, output rate_sample, output time_step, input ready);
  modport sink   (input valid, input rate_sample, input time_step, output ready);
endinterface

interface ssi_out_if import ssi_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

/* design/ssi_window.sv */
// ----------------------------------------------------------------------------
// ssi_window: sample window
// Shift line of the last WINDOW_LEN samples; load shifts a new sample in at
// the newest end, rotate cycles the line so every tap passes the head.
// ----------------------------------------------------------------------------
module ssi_window import ssi_pkg::*; #(
  parameter int WINDOW_LEN = 9
) (
  input  logic      clk,
  input  logic      rst,
  input  win_ctrl_t ctrl,
  input  sample_t   new_sample,
  output sample_t   head
);

  sample_t win [WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= '0;
      end
    end else if (ctrl.load || ctrl.rotate) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WINDOW_LEN-1] <= ctrl.load ? new_sample : win[0];
    end
  end

  assign head = win[0];

endmodule

/* design/ssi_div3.sv */
// ----------------------------------------------------------------------------
// ssi_div3: divide by three
// Reciprocal multiply by ceil(2^DIV_W / 3), high half kept; the quotient is
// registered on start and held until the next start.
// ----------------------------------------------------------------------------
module ssi_div3 import ssi_pkg::*; #(
  parameter int DIV_W = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic [DIV_W-1:0] quotient
);

  // exact floor(x / 3) for any dividend below 2^(DIV_W-2)
  localparam logic [DIV_W-1:0] RECIP = DIV_W'(((64'd1 << DIV_W) / DIVISOR) + 1);

  logic [2*DIV_W-1:0] scaled;

  assign scaled = (2*DIV_W)'(dividend) * (2*DIV_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient <= '0;
    end else if (start) begin
      quotient <= scaled[2*DIV_W-1:DIV_W];
    end
  end

endmodule

/* design/sliding_simpson_integrator.sv */
// The sequencer takes one sample word at a time: the one accumulator walks
// the window one tap a cycle, then two passes go through the shared
// divide-by-three unit; a held angle word stalls the next.
// Reset (rst, synchronous): window cleared to zero, sequencer idle, no word out.
// ----------------------------------------------------------------------------
// sliding_simpson_integrator: sliding-window composite Simpson integrator
// Keeps the last WINDOW_LEN rate samples, forms the Simpson weighted sum,
// scales it by time_step / 3 (truncated toward zero) and emits the angle.
// ----------------------------------------------------------------------------
module sliding_simpson_integrator import ssi_pkg::*; #(
  parameter int WINDOW_LEN = 9
) (
  input  logic clk,
  input  logic rst,
  ssi_in_if.sink    sample,
  ssi_out_if.source result
);

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  // weights reach at most 5 per tap; signed headroom for the whole window
  localparam int SUM_W  = SAMPLE_W + 3 + IDX_W;
  localparam int PROD_W = SUM_W + STEP_W;
  // remainder (0..2) times time_step
  localparam int PART_W = 2 + STEP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  // with an even window the newest tap sits on an odd index: weight 1 + 4
  localparam bit LAST_ODD = ((WINDOW_LEN - 1) % 2) == 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_ACCUM  = 8'b00000010,
    S_ABS    = 8'b00000100,
    S_THIRD  = 8'b00001000,
    S_REMAIN = 8'b00010000,
    S_SCALE  = 8'b00100000,
    S_FRAC   = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0]         idx;
  logic signed [SUM_W-1:0]  acc;
  step_t                    dt;
  logic                     neg;
  logic [SUM_W-1:0]         mag;
  logic [1:0]               rem;
  logic [PROD_W-1:0]        whole;
  logic [PART_W-1:0]        part;
  logic [PROD_W-1:0]        total;
  logic [PROD_W-1:0]        signed_total;
  logic                     out_valid;
  angle_t                   out_angle;

  win_ctrl_t                win_ctrl;
  sample_t                  head;
  logic signed [SUM_W-1:0]  head_ext;
  logic signed [SUM_W-1:0]  term;

  logic                     div_start;
  logic [SUM_W-1:0]         div_dividend;
  logic [SUM_W-1:0]         quotient;

  logic in_take;
  logic out_free;

  assign in_take  = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  // -------------------------------------------------------------------------
  // Window: the new sample shifts in on acceptance, then the line rotates
  // once per ACCUM cycle so tap idx sits at the head; after WINDOW_LEN
  // rotations it is back in order for the next word.
  // -------------------------------------------------------------------------
  assign win_ctrl.load   = in_take;
  assign win_ctrl.rotate = (state == S_ACCUM);

  ssi_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (win_ctrl),
    .new_sample (sample.rate_sample),
    .head       (head)
  );

  // Simpson weight for the tap at the head: ends 1, odd 4, interior even 2; a newest tap on an odd index takes 1 + 4
  assign head_ext = SUM_W'(head);

  always_comb begin
    if (idx == '0) begin
      term = head_ext;
    end else if (idx == LAST_IDX) begin
      term = LAST_ODD ? (head_ext <<< 2) + head_ext : head_ext;
    end else if (idx[0]) begin
      term = head_ext <<< 2;
    end else begin
      term = head_ext <<< 1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) state_next = S_ACCUM;
      end
      S_ACCUM: begin
        if (idx == LAST_IDX) state_next = S_ABS;
      end
      S_ABS: begin
        state_next = S_THIRD;
      end
      S_THIRD: begin
        state_next = S_REMAIN;
      end
      S_REMAIN: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_FRAC;
      end
      S_FRAC: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Scaling: with |W| = 3q + r, |W| * dt / 3 = q * dt + (r * dt) / 3, so the
  // one divide-by-three unit is used twice on narrow operands. The sign goes
  // back on at the end, so the result truncates toward zero.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          idx <= '0;
          acc <= '0;
          dt  <= sample.time_step;
        end
      end
      S_ACCUM: begin
        acc <= acc + term;
        idx <= idx + IDX_W'(1);
      end
      S_ABS: begin
        neg <= acc[SUM_W-1];
        mag <= acc[SUM_W-1] ? $unsigned(-acc) : $unsigned(acc);
      end
      S_REMAIN: begin
        // quotient holds |W| / 3 here
        rem   <= 2'(mag - quotient - (quotient << 1));
        whole <= PROD_W'(quotient) * PROD_W'(dt);
      end
      S_SCALE: begin
        part <= PART_W'(rem) * PART_W'(dt);
      end
      S_FINISH: begin
        if (out_free) out_angle <= signed_total[ANGLE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // first pass divides |W| (from THIRD), second pass r * dt (from FRAC)
  assign div_start    = (state == S_THIRD) || (state == S_FRAC);
  assign div_dividend = (state == S_FRAC) ? SUM_W'(part) : mag;

  ssi_div3 #(.DIV_W(SUM_W)) u_div3 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .quotient (quotient)
  );

  // low ANGLE_W bits of the signed result form the angle
  assign total        = whole + PROD_W'(quotient);
  assign signed_total = neg ? -total : total;

  assign sample.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.angle = out_angle;

`ifndef SYNTHESIS
  a_take_starts_accum: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_ACCUM) && (idx == '0))
    else $error("accepted word did not start accumulation");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && out_free |=> out_valid && (state == S_IDLE))
    else $error("finished word not presented");

  a_angle_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_angle))
    else $error("waiting angle word changed or dropped");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE) |-> (rem != 2'd3))
    else $error("remainder out of range");
`endif

endmodule

/* tb/sv/angle_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_checker: scoreboard for the sliding Simpson integrator
// Watches both word channels. It keeps its own copy of the sample window and
// works out the angle for every accepted sample word. Each accepted angle
// word is then compared with the oldest angle still awaited.
// ----------------------------------------------------------------------------
module angle_checker import ssi_pkg::*; #(
  parameter int WINDOW_LEN = 9
) (
  input  logic clk,
  input  logic rst,
  ssi_in_if    in_ch,
  ssi_out_if   out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   angles_checked
);

  sample_t window_q [WINDOW_LEN];   // entry 0 oldest, last entry newest
  angle_t  awaited_angles [$];
  int      fail_tally = 0;
  int      awaited_count = 0;
  int      checked_tally = 0;

  assign mismatches     = fail_tally;
  assign outstanding    = awaited_count;
  assign angles_checked = checked_tally;

  // shift the sample in, weight the window 1-4-2-...-4-1, scale by dt / 3
  function automatic angle_t simpson_angle(input sample_t rate, input step_t dt);
    longint weighted;
    longint quotient;
    int     weight;
    weighted = 0;
    for (int i = 0; i < WINDOW_LEN - 1; i++) window_q[i] = window_q[i + 1];
    window_q[WINDOW_LEN - 1] = rate;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      weight = 0;
      if (i == 0 || i == WINDOW_LEN - 1) weight += 1;
      // even lengths: newest tap is also odd, so it collects 1 + 4
      if (i % 2 == 1) weight += 4;
      else if (i != 0 && i != WINDOW_LEN - 1) weight += 2;
      weighted += longint'(window_q[i]) * weight;
    end
    // signed divide truncates toward zero; long windows wrap to 36 bits
    quotient = (weighted * longint'(dt)) / 3;
    return quotient[ANGLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    angle_t want;
    if (rst) begin
      foreach (window_q[i]) window_q[i] = '0;
      awaited_angles.delete();
    end else begin
      // older words leave before this edge's sample word is queued
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_angles.size() == 0) begin
          $display("%0t: angle word %0d with none awaited (expected nothing)",
                   $time, out_ch.angle);
          fail_tally++;
        end else begin
          want = awaited_angles.pop_front();
          checked_tally++;
          if (want !== out_ch.angle) begin
            $display("%0t: angle mismatch: expected %0d, actual %0d",
                     $time, want, out_ch.angle);
            fail_tally++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_angles.push_back(simpson_angle(in_ch.rate_sample, in_ch.time_step));
    end
    awaited_count = awaited_angles.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sliding Simpson integrator
// Drives sample words into the integrator and drains angle words, both with
// random gaps. One long hold on the result side lets the pipeline back up
// into the sample channel. The checker beside the DUT does all prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ssi_pkg::*;

  localparam int WINDOW_LEN   = 9;
  // bound on the DUT's latency, kept loose
  localparam int LATENCY      = WINDOW_LEN + 30;
  localparam int RANDOM_WORDS = 1050;
  localparam int HOLD_CYCLES  = 400;
  // worst case per word: full pipeline, longest sender gap, receiver stalls
  localparam int CYCLE_LIMIT  = 6 * (RANDOM_WORDS + 2 * WINDOW_LEN + 20) * (2 * LATENCY + 20)
                                + 10 * HOLD_CYCLES;

  logic clk = 1'b0;
  logic rst;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ssi_in_if  sample_ch ();
  ssi_out_if result_ch ();

  sliding_simpson_integrator #(
    .WINDOW_LEN(WINDOW_LEN)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  int fail_count;
  int pending;
  int checked;

  angle_checker #(
    .WINDOW_LEN(WINDOW_LEN)
  ) angle_check (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (sample_ch),
    .out_ch        (result_ch),
    .mismatches    (fail_count),
    .outstanding   (pending),
    .angles_checked(checked)
  );

  // idling switches: tx for the sender, rx for the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  // result-side hold: requested by the stimulus, counted by the receiver
  bit hold_off_go = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int input_stall_cycles = 0;
  int words_sent = 0;
  int unsigned cycle_count = 0;

  // Offer one sample word and wait for it to be taken. valid stays high
  // into the next word unless a gap is drawn, so it never drops and rises
  // in the same step. Gaps run up to the loose LATENCY bound, so they land on
  // every phase of the window walk and the divide.
  task automatic send_word(input sample_t rate, input step_t dt);
    if (tx_idle_on && $urandom_range(0, 99) < 10) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, LATENCY)) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.rate_sample <= rate;
    sample_ch.time_step   <= dt;
    do @(posedge clk); while (!sample_ch.ready);
    words_sent++;
  endtask

  // Receiver: about 9 idle cycles in a hundred, plus one long hold.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // count the cycles the block is pushing back on the sample side
        if (sample_ch.valid && !sample_ch.ready) input_stall_cycles++;
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 9) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d angle words still awaited",
             cycle_count, pending);
    $display("sliding_simpson_integrator test failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    sample_t rate;
    step_t   dt;
    int      pick;

    sample_ch.valid       <= 1'b0;
    sample_ch.rate_sample <= '0;
    sample_ch.time_step   <= '0;
    rst                   <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed words ---
    // lone -1 at weight 1: -1/3 must truncate to 0, not -1
    send_word(-16'sd1, 16'd1);
    // -1 now at an odd tap: -5 * 2 / 3 -> -3
    send_word(-16'sd1, 16'd2);
    // full-scale positive window at the longest step: largest angle
    for (int i = 0; i < WINDOW_LEN; i++) send_word(16'sh7fff, 16'hffff);
    // full-scale negative window: most negative angle
    for (int i = 0; i < WINDOW_LEN; i++) send_word(16'sh8000, 16'hffff);
    // zero step gives 0 while the window keeps shifting
    send_word(16'sd0, 16'd0);
    send_word(16'sd21845, 16'd0);
    send_word(16'sh8000, 16'd3);
    send_word(16'sh7fff, 16'h8000);

    // --- random words ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // one long receiver hold while words keep coming
      if (n == 150) hold_off_go = 1'b1;
      // a stretch with no idling on either side
      tx_idle_on = !(n >= 350 && n < 550);
      rx_idle_on = tx_idle_on;

      pick = $urandom_range(0, 9);
      case (pick)
        0:       rate = 16'sh7fff;
        1:       rate = 16'sh8000;
        2:       rate = '0;
        3:       rate = sample_t'($urandom_range(0, 15) - 8);
        default: rate = sample_t'($urandom);
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       dt = '0;
        1:       dt = '1;
        2:       dt = step_t'($urandom_range(1, 7));
        default: dt = step_t'($urandom);
      endcase
      send_word(rate, dt);
    end
    sample_ch.valid <= 1'b0;

    // drain, then give the pipeline time to show any stray word
    while (pending != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Sent %0d sample words through a %0d-tap window, %0d angle words checked.",
             words_sent, WINDOW_LEN, checked);
    $display("Result hold of %0d cycles backed up the sample side for %0d cycles.",
             HOLD_CYCLES, input_stall_cycles);
    if (pending != 0) $display("%0d angle words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_simpson_integrator test passed");
    end else begin
      $display("sliding_simpson_integrator test failed");
    end
    $finish;
  end

endmodule
